/* rtl/assert_macros.svh */
// Assertion macros for the checker file of the compressor.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ACS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds during reset.
`define ACS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/acs_pkg.sv */
// Constants, register codes and the sine divisor tables of the compressor.
// No dependencies.
`default_nettype none

package acs_pkg;

    localparam logic [31:0] ONE30         = 32'h4000_0000;
    localparam logic [31:0] ONE20         = 32'h0010_0000;
    localparam logic [31:0] NINE_TENTHS   = 32'd966367642;
    localparam logic [31:0] ELEVEN_TENTHS = 32'd1181116006;
    localparam logic [31:0] HALF_PI       = 32'd1686629713;
    localparam logic [31:0] ADJ_MULT      = 32'd92;
    localparam logic [31:0] ADJ_BASE      = 32'd6029312;
    localparam logic [18:0] RATE_MIN      = 19'd8192;

    localparam logic [15:0] PRESSURE_RESET = 16'd32768;
    localparam logic [15:0] MIX_RESET      = 16'd32768;
    localparam logic [18:0] RATE_RESET     = 19'd65536;
    localparam logic [31:0] GAIN_RESET     = 32'h4000_0000;
    localparam logic [31:0] SPEED_RESET    = 32'd104857600;

    localparam int NUM_W = 64;
    localparam int DEN_W = 32;

    localparam logic [2:0] SINE_LAST = 3'd4;

    localparam logic [1:0] REG_PRESSURE = 2'd0;
    localparam logic [1:0] REG_MIX      = 2'd1;
    localparam logic [1:0] REG_RATE     = 2'd2;

    // Horner divisors of the sine series, innermost (highest-order) term first
    function automatic logic [31:0] sine_div(input logic [2:0] k);
        logic [31:0] d;
        case (k)
            3'd0:    d = 32'd110;
            3'd1:    d = 32'd72;
            3'd2:    d = 32'd42;
            3'd3:    d = 32'd20;
            3'd4:    d = 32'd6;
            default: d = 32'd6;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor); the quotient it gives is short by at most one
    function automatic logic [31:0] sine_recip(input logic [2:0] k);
        logic [31:0] r;
        case (k)
            3'd0:    r = 32'd39045157;
            3'd1:    r = 32'd59652323;
            3'd2:    r = 32'd102261126;
            3'd3:    r = 32'd214748364;
            3'd4:    r = 32'd715827882;
            default: r = 32'd715827882;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/acs_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on acs_pkg for the operand widths.
`default_nettype none

module acs_div
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [acs_pkg::NUM_W-1:0]  dividend,
    input  wire logic [acs_pkg::DEN_W-1:0]  divisor,
    output logic                            done,
    output logic [acs_pkg::NUM_W-1:0]       quotient
);

    localparam int CNT_W = $clog2(acs_pkg::NUM_W + 1);

    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [acs_pkg::DEN_W-1:0]   rem_reg;
    logic [acs_pkg::DEN_W-1:0]   den_reg;
    logic [acs_pkg::NUM_W-1:0]   quo_reg;
    logic [acs_pkg::DEN_W:0]     shifted;
    logic                        fits;

    assign shifted = {rem_reg, quo_reg[acs_pkg::NUM_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rem_reg  <= '0;
            den_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(acs_pkg::NUM_W);
                busy_reg <= 1'b1;
                rem_reg  <= '0;
                den_reg  <= divisor;
                quo_reg  <= dividend;
            end
            else if (busy_reg)
            begin
                // shift in one dividend bit, subtract where it fits
                if (fits)
                begin
                    rem_reg <= acs_pkg::DEN_W'(shifted - {1'b0, den_reg});
                end
                else
                begin
                    rem_reg <= shifted[acs_pkg::DEN_W-1:0];
                end
                quo_reg <= {quo_reg[acs_pkg::NUM_W-2:0], fits};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* rtl/adaptive_compressor_saturator.sv */
// Top level of the mono adaptive compressor with sine-shaped saturation.
// Depends on acs_pkg and acs_div.
`default_nettype none

// One sample word enters on the s_axis side and one processed word leaves on
// the m_axis side, with tlast copied through. The block works on one sample
// at a time: it drops s_axis_tready after taking a word and raises it again
// once the result sits in the output register; a finished result waits only
// while the previous word is still unaccepted in that register. All
// arithmetic runs on one shared 32x32 multiplier and one 64/32 radix-2
// divider under a step sequencer; the constant divides of the sine series go
// through the multiplier as a reciprocal product with a one-step remainder
// fix. A sample needs 4 variable divides (3 on the attack path with the level
// above unity). Registers sit on the APB port: pressure at 0x0, mix at 0x4,
// rate scale at 0x8. Write them only while the block is idle. Gain (Q2.30)
// and speed (Q12.20) state reset to 1.0 and 100.0.
module adaptive_compressor_saturator
#(
    parameter int SAMPLE_BITS = 24
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // sample word: sample_in [SAMPLE_BITS-1:0], zero padding above
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
    input  wire logic                                   s_axis_tvalid,
    input  wire logic                                   s_axis_tlast,
    output logic                                        s_axis_tready,
    // result word: sample_out [SAMPLE_BITS-1:0], zero padding above
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]            m_axis_tdata,
    output logic                                        m_axis_tvalid,
    output logic                                        m_axis_tlast,
    input  wire logic                                   m_axis_tready,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [3:0]                             paddr,
    input  wire logic [31:0]                            pwdata,
    output logic [31:0]                                 prdata,
    output logic                                        pready
);

    localparam int SFRAC  = SAMPLE_BITS - 1;
    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam logic [SAMPLE_BITS-1:0] HI = {1'b0, {SFRAC{1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] LO = {1'b1, {SFRAC{1'b0}}};

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DIV, ST_DONE} state_t;

    typedef enum logic [4:0] {
        K_Q, K_Q2, K_Q3, K_T, K_ADJ, K_W, K_DC, K_R, K_M, K_INC, K_STEP2,
        K_GN, K_GG, K_M2, K_TERM, K_SPD, K_SN, K_X2, K_SIN, K_SQ, K_H, K_WP,
        K_DRY, K_OUT
    } step_t;

    state_t state_reg;
    step_t  step_reg;

    // configuration
    logic [15:0] pressure_reg;
    logic [15:0] mix_reg;
    logic [18:0] rate_reg;

    // persistent state
    logic [31:0] gain_reg;
    logic [31:0] speed_reg;

    // per-sample working registers
    logic [SAMPLE_BITS-1:0] ax_reg;
    logic                   neg_reg;
    logic                   last_reg;
    logic                   sub_reg;
    logic [31:0]            q_reg;
    logic [31:0]            t_reg;
    logic [31:0]            adj_reg;
    logic [31:0]            w_reg;
    logic [31:0]            dc_reg;
    logic [31:0]            m_reg;
    logic [31:0]            m2_reg;
    logic [31:0]            vw_reg;
    logic [31:0]            x2_reg;
    logic [31:0]            h_reg;
    logic [2:0]             k_reg;
    logic [31:0]            sdn_reg;
    logic [31:0]            sq_reg;
    logic [31:0]            wp_reg;
    logic [63:0]            prod_reg;
    logic [SAMPLE_BITS-1:0] res_reg;

    // output register
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_sample_reg;
    logic                   out_last_reg;

    // shared units
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod_w;
    logic        div_start;
    logic [63:0] div_num;
    logic [31:0] div_den;
    logic        div_done;
    logic [63:0] quo;

    // derived values
    logic [31:0]            p30;
    logic [31:0]            m_next;
    logic [31:0]            spd_eff;
    logic [18:0]            rs;
    logic [31:0]            adj_factor;
    logic [63:0]            gsum;
    logic [31:0]            gain_next;
    logic [63:0]            ssum;
    logic [63:0]            adj2;
    logic [31:0]            speed_next;
    logic [31:0]            vw_next;
    logic [31:0]            srem;
    logic [31:0]            squo;
    logic [31:0]            h_next;
    logic [63:0]            mag;
    logic [63:0]            rnd;
    logic [SAMPLE_BITS-1:0] res_next;
    logic [SAMPLE_BITS-1:0] sample_w;
    logic                   cfg_write;
    logic                   out_load;

    assign p30        = prod_reg[61:30];
    assign m_next     = prod_reg[SFRAC+31:SFRAC];
    assign spd_eff    = (speed_reg == 32'd0) ? 32'd1 : speed_reg;
    assign rs         = (rate_reg < acs_pkg::RATE_MIN) ? acs_pkg::RATE_MIN : rate_reg;
    assign adj_factor = 32'(pressure_reg) * acs_pkg::ADJ_MULT + acs_pkg::ADJ_BASE;
    assign prod_w     = 64'(mul_a) * 64'(mul_b);
    assign sample_w   = s_axis_tdata[SAMPLE_BITS-1:0];

    // gain update, clamped to [t, 1]
    always_comb
    begin
        gsum = sub_reg ? (64'(gain_reg) - quo) : (64'(gain_reg) + quo);
        if ($signed(gsum) > $signed(64'(acs_pkg::ONE30)))
        begin
            gain_next = acs_pkg::ONE30;
        end
        else if ($signed(gsum) < $signed(64'(t_reg)))
        begin
            gain_next = t_reg;
        end
        else
        begin
            gain_next = gsum[31:0];
        end
    end

    // speed update, clamped to [adj, 2*adj]
    always_comb
    begin
        ssum = 64'(spd_eff) - 64'(acs_pkg::ONE20) + quo;
        adj2 = 64'(adj_reg) << 1;
        if ($signed(ssum) > $signed(adj2))
        begin
            speed_next = adj2[31:0];
        end
        else if ($signed(ssum) < $signed(64'(adj_reg)))
        begin
            speed_next = adj_reg;
        end
        else
        begin
            speed_next = ssum[31:0];
        end
    end

    assign vw_next = (p30 > acs_pkg::HALF_PI) ? acs_pkg::HALF_PI : p30;

    // sine series divide: the reciprocal quotient is short by at most one,
    // bump it when the remainder still holds a whole divisor
    assign srem    = sdn_reg - prod_reg[31:0];
    assign squo    = sq_reg + ((srem >= acs_pkg::sine_div(k_reg)) ? 32'd1 : 32'd0);
    assign h_next  = (squo > acs_pkg::ONE30) ? 32'd0 : (acs_pkg::ONE30 - squo);

    // dry and wet share the sign of the input: sum magnitudes, round half
    // away from zero, then saturate
    always_comb
    begin
        mag = prod_reg + (64'(wp_reg) << SFRAC);
        rnd = (mag + 64'(32'h2000_0000)) >> 30;
        if (!neg_reg)
        begin
            res_next = (rnd > 64'(HI)) ? HI : rnd[SAMPLE_BITS-1:0];
        end
        else
        begin
            res_next = (rnd > 64'(LO)) ? LO : (-rnd[SAMPLE_BITS-1:0]);
        end
    end

    // operand select for the shared multiplier and divider
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = spd_eff;
        if (state_reg == ST_RUN)
        begin
            case (step_reg)
                K_Q:
                begin
                    mul_a = 32'(pressure_reg);
                    mul_b = acs_pkg::NINE_TENTHS;
                end
                K_Q2:
                begin
                    mul_a = prod_reg[47:16];
                    mul_b = prod_reg[47:16];
                end
                K_Q3:
                begin
                    mul_a = p30;
                    mul_b = q_reg;
                end
                K_T:
                begin
                    mul_a = adj_factor;
                    mul_b = 32'(rs);
                end
                K_ADJ:
                begin
                    mul_a = 32'(mix_reg);
                    mul_b = acs_pkg::NINE_TENTHS;
                end
                K_W:
                begin
                    mul_a = prod_reg[47:16];
                    mul_b = acs_pkg::ELEVEN_TENTHS;
                end
                K_DC:
                begin
                    div_start = 1'b1;
                    div_num   = 64'(gain_reg) << 30;
                    div_den   = t_reg;
                end
                K_R:
                begin
                    mul_a = 32'(ax_reg);
                    mul_b = quo[31:0];
                end
                K_M:
                begin
                    if (m_next > t_reg)
                    begin
                        if (m_next > acs_pkg::ONE30)
                        begin
                            mul_a = t_reg;
                            mul_b = m_next;
                        end
                        else
                        begin
                            div_start = 1'b1;
                            div_num   = 64'(t_reg) << 30;
                            div_den   = m_next;
                        end
                    end
                    else
                    begin
                        div_start = 1'b1;
                        div_num   = 64'(acs_pkg::ELEVEN_TENTHS + t_reg - m_next) << 20;
                    end
                end
                K_INC:
                begin
                    div_start = 1'b1;
                    div_num   = 64'(p30) << 20;
                end
                K_STEP2:
                begin
                    div_start = 1'b1;
                    div_num   = quo << 20;
                end
                K_GG:
                begin
                    mul_a = gain_reg;
                    mul_b = gain_reg;
                end
                K_M2:
                begin
                    mul_a = m_reg;
                    mul_b = p30;
                end
                K_TERM:
                begin
                    mul_a = p30;
                    mul_b = adj_reg;
                end
                K_SPD:
                begin
                    div_start = 1'b1;
                    div_num   = 64'(prod_reg[63:30]) << 20;
                    mul_a     = m2_reg;
                    mul_b     = w_reg;
                end
                K_SN:
                begin
                    mul_a = vw_next;
                    mul_b = vw_next;
                end
                K_X2:
                begin
                    mul_a = p30;
                    mul_b = h_reg;
                end
                K_SIN:
                begin
                    mul_a = p30;
                    mul_b = acs_pkg::sine_recip(k_reg);
                end
                K_SQ:
                begin
                    mul_a = prod_reg[63:32];
                    mul_b = acs_pkg::sine_div(k_reg);
                end
                K_H:
                begin
                    mul_a = (k_reg == acs_pkg::SINE_LAST) ? vw_reg : x2_reg;
                    mul_b = h_next;
                end
                K_WP:
                begin
                    mul_a = p30;
                    mul_b = w_reg;
                end
                K_DRY:
                begin
                    mul_a = 32'(ax_reg);
                    mul_b = dc_reg;
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    acs_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (quo)
    );

    assign cfg_write = psel && penable && pwrite;

    // advance the finished result once the output register is free
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= K_Q;
            pressure_reg   <= acs_pkg::PRESSURE_RESET;
            mix_reg        <= acs_pkg::MIX_RESET;
            rate_reg       <= acs_pkg::RATE_RESET;
            gain_reg       <= acs_pkg::GAIN_RESET;
            speed_reg      <= acs_pkg::SPEED_RESET;
            ax_reg         <= '0;
            neg_reg        <= 1'b0;
            last_reg       <= 1'b0;
            sub_reg        <= 1'b0;
            q_reg          <= '0;
            t_reg          <= '0;
            adj_reg        <= '0;
            w_reg          <= '0;
            dc_reg         <= '0;
            m_reg          <= '0;
            m2_reg         <= '0;
            vw_reg         <= '0;
            x2_reg         <= '0;
            h_reg          <= '0;
            k_reg          <= '0;
            sdn_reg        <= '0;
            sq_reg         <= '0;
            wp_reg         <= '0;
            prod_reg       <= '0;
            res_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_sample_reg <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (paddr[3:2])
                    acs_pkg::REG_PRESSURE: pressure_reg <= pwdata[15:0];
                    acs_pkg::REG_MIX:      mix_reg      <= pwdata[15:0];
                    acs_pkg::REG_RATE:     rate_reg     <= pwdata[18:0];
                    default:               ;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg  <= 1'b1;
                out_sample_reg <= res_reg;
                out_last_reg   <= last_reg;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            // hold the product while the divider runs
            if (state_reg == ST_RUN)
            begin
                prod_reg <= prod_w;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        neg_reg   <= sample_w[SAMPLE_BITS-1];
                        ax_reg    <= sample_w[SAMPLE_BITS-1] ? (-sample_w) : sample_w;
                        last_reg  <= s_axis_tlast;
                        step_reg  <= K_Q;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    case (step_reg)
                        K_Q:   step_reg <= K_Q2;
                        K_Q2:
                        begin
                            q_reg    <= prod_reg[47:16];
                            step_reg <= K_Q3;
                        end
                        K_Q3:  step_reg <= K_T;
                        K_T:
                        begin
                            t_reg    <= acs_pkg::ONE30 - p30;
                            step_reg <= K_ADJ;
                        end
                        K_ADJ:
                        begin
                            adj_reg  <= prod_reg[43:12];
                            step_reg <= K_W;
                        end
                        K_W:
                        begin
                            w_reg    <= prod_reg[47:16];
                            step_reg <= K_DC;
                        end
                        K_DC:
                        begin
                            dc_reg    <= acs_pkg::ONE30 - p30;
                            step_reg  <= K_R;
                            state_reg <= ST_DIV;
                        end
                        K_R:   step_reg <= K_M;
                        K_M:
                        begin
                            m_reg <= m_next;
                            if (m_next > t_reg)
                            begin
                                if (m_next > acs_pkg::ONE30)
                                begin
                                    sub_reg  <= 1'b0;
                                    step_reg <= K_INC;
                                end
                                else
                                begin
                                    sub_reg   <= 1'b1;
                                    step_reg  <= K_STEP2;
                                    state_reg <= ST_DIV;
                                end
                            end
                            else
                            begin
                                sub_reg   <= 1'b0;
                                step_reg  <= K_STEP2;
                                state_reg <= ST_DIV;
                            end
                        end
                        K_INC, K_STEP2:
                        begin
                            step_reg  <= K_GN;
                            state_reg <= ST_DIV;
                        end
                        K_GN:
                        begin
                            gain_reg <= gain_next;
                            step_reg <= K_GG;
                        end
                        K_GG:  step_reg <= K_M2;
                        K_M2:  step_reg <= K_TERM;
                        K_TERM:
                        begin
                            m2_reg   <= p30;
                            step_reg <= K_SPD;
                        end
                        K_SPD:
                        begin
                            step_reg  <= K_SN;
                            state_reg <= ST_DIV;
                        end
                        K_SN:
                        begin
                            speed_reg <= speed_next;
                            vw_reg    <= vw_next;
                            h_reg     <= acs_pkg::ONE30;
                            k_reg     <= '0;
                            step_reg  <= K_X2;
                        end
                        K_X2:
                        begin
                            x2_reg   <= p30;
                            step_reg <= K_SIN;
                        end
                        K_SIN:
                        begin
                            sdn_reg  <= p30;
                            step_reg <= K_SQ;
                        end
                        K_SQ:
                        begin
                            sq_reg   <= prod_reg[63:32];
                            step_reg <= K_H;
                        end
                        K_H:
                        begin
                            h_reg <= h_next;
                            if (k_reg == acs_pkg::SINE_LAST)
                            begin
                                step_reg <= K_WP;
                            end
                            else
                            begin
                                k_reg    <= k_reg + 3'd1;
                                step_reg <= K_SIN;
                            end
                        end
                        K_WP:  step_reg <= K_DRY;
                        K_DRY:
                        begin
                            wp_reg   <= p30;
                            step_reg <= K_OUT;
                        end
                        K_OUT:
                        begin
                            res_reg   <= res_next;
                            state_reg <= ST_DONE;
                        end
                        default: state_reg <= ST_IDLE;
                    endcase
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            acs_pkg::REG_PRESSURE: prdata = 32'(pressure_reg);
            acs_pkg::REG_MIX:      prdata = 32'(mix_reg);
            acs_pkg::REG_RATE:     prdata = 32'(rate_reg);
            default:               prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = DATA_W'(out_sample_reg);
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

/* rtl/acs_checker.sv */
// Port-level checker for the compressor, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module acs_checker
#(
    parameter int SAMPLE_BITS = 24
)
(
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,
    input wire logic                               s_axis_tvalid,
    input wire logic                               s_axis_tlast,
    input wire logic                               s_axis_tready,
    input wire logic [((SAMPLE_BITS+7)/8)*8-1:0]   m_axis_tdata,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tlast,
    input wire logic                               m_axis_tready,
    input wire logic                               psel,
    input wire logic                               penable,
    input wire logic                               pwrite,
    input wire logic [3:0]                         paddr,
    input wire logic [31:0]                        pwdata,
    input wire logic [31:0]                        prdata,
    input wire logic                               pready
);

    `ACS_ASSERT(a_busy_after_take, clk, rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while a sample is in work")
    `ACS_ASSERT(a_no_instant_result, clk, rst_n, s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid), "result appeared one cycle after a take")
    `ACS_ASSERT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result word changed")
    `ACS_ASSERT_ALWAYS(a_pready_high, clk, pready, "pready dropped")

endmodule

bind adaptive_compressor_saturator acs_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_acs_checker (.*);

`default_nettype wire

/* tb/sv/adaptive_compressor_saturator_test.sv */
// Self-checking testbench for the adaptive compressor: drives sample words with
// random gaps and stalls and checks every output word against a predictor or a typed-in value.
// Depends on acs_pkg and the adaptive_compressor_saturator RTL.
`timescale 1ns / 100ps

module adaptive_compressor_saturator_test;

    localparam int SBITS = 24;
    // settle time after the last word, sized above the worst case per sample
    localparam int DRAIN_CYCLES = 800;

    typedef struct packed {
        logic [SBITS-1:0] sample;
        logic             last;
    } word_t;

    // one row of the directed table: known=1 means want is typed in
    typedef struct packed {
        logic [SBITS-1:0] sample;
        logic             last;
        logic             known;
        logic [SBITS-1:0] want;
    } row_t;

    localparam int DIRECTED_ROWS = 20;
    localparam logic [SBITS-1:0] S_MAX  = 24'h7FFFFF;
    localparam logic [SBITS-1:0] S_MIN  = 24'h800000;
    localparam logic [SBITS-1:0] S_ZERO = 24'h000000;

    logic              clk;
    logic              rst_n;
    logic [SBITS-1:0]  s_axis_tdata;
    logic              s_axis_tvalid;
    logic              s_axis_tlast;
    logic              s_axis_tready;
    logic [SBITS-1:0]  m_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tlast;
    logic              m_axis_tready;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [3:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // predictor copy of the registers and of the gain and speed state
    logic [15:0]       pressure_q;
    logic [15:0]       mix_q;
    logic [18:0]       rate_q;
    logic [31:0]       gain_q;
    logic [31:0]       speed_q;

    word_t             expected_words[$];
    int                error_count;
    int                words_sent;
    int                words_checked;
    int                settings_used;
    bit                tx_gaps_on;
    bit                rx_stalls_on;
    int                rx_hold;

    adaptive_compressor_saturator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),   // sample_in [23:0]
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),   // block_last
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // sample_out [23:0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tlast  (m_axis_tlast),   // block_last_out
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Hard stop. About 1050 words with long gaps, stalls and drains
    // stay well under a tenth of this.
    initial
    begin
        #200_000_000;
        $display("adaptive_compressor_saturator_test: errors");
        $finish;
    end

    // Sine of x (Q.30, 0..pi/2) by Horner over the Taylor series to x^11.
    function automatic longint unsigned sine_of(input longint unsigned x);
        longint unsigned x2;
        longint unsigned h;
        longint unsigned d;
        longint unsigned divisors[5];
        divisors = '{110, 72, 42, 20, 6};
        x2 = (x * x) >> 30;
        h  = acs_pkg::ONE30;
        for (int i = 0; i < 5; i++)
        begin
            d = ((x2 * h) >> 30) / divisors[i];
            h = (d > acs_pkg::ONE30) ? 0 : acs_pkg::ONE30 - d;
        end
        return (x * h) >> 30;
    endfunction

    // Advance the gain and speed state by one sample and return the output.
    function automatic logic [SBITS-1:0] compress_sample(input logic [SBITS-1:0] smp);
        longint          x;
        longint unsigned ax, q, q2, q3, thr, rs, adj, wet_amt, w11, dry_amt;
        longint unsigned g, spd, ratio, lvl, gg, lvl2, term, vw, sv, wp, mag, rnd;
        longint unsigned inc, dec, num, s1;
        longint          gn, sn, dry, wet, total, res;
        bit              neg;
        x   = $signed(smp);
        neg = x < 0;
        ax  = neg ? longint'(-x) : longint'(x);

        // derived from the registers
        q       = (longint'(pressure_q) * acs_pkg::NINE_TENTHS) >> 16;
        q2      = (q * q) >> 30;
        q3      = (q2 * q) >> 30;
        thr     = acs_pkg::ONE30 - q3;
        rs      = (rate_q < acs_pkg::RATE_MIN) ? acs_pkg::RATE_MIN : rate_q;
        adj     = ((92 * longint'(pressure_q) + 92 * 65536) * rs) >> 12;
        wet_amt = (longint'(mix_q) * acs_pkg::NINE_TENTHS) >> 16;
        w11     = (wet_amt * acs_pkg::ELEVEN_TENTHS) >> 30;
        dry_amt = acs_pkg::ONE30 - w11;

        g   = gain_q;
        spd = speed_q;
        if (spd == 0)
            spd = 1;

        ratio = (g << 30) / thr;
        lvl   = (ax * ratio) >> (SBITS - 1);

        if (lvl > thr)
        begin
            if (lvl > acs_pkg::ONE30)
            begin
                inc = (thr * lvl) >> 30;
                gn  = longint'(g) + longint'((inc << 20) / spd);
            end
            else
            begin
                dec = (thr << 30) / lvl;
                gn  = longint'(g) - longint'((dec << 20) / spd);
            end
        end
        else
        begin
            // recovery divides by the speed twice
            num = acs_pkg::ELEVEN_TENTHS + thr - lvl;
            s1  = (num << 20) / spd;
            gn  = longint'(g) + longint'((s1 << 20) / spd);
        end
        if (gn > longint'(acs_pkg::ONE30))
            gn = acs_pkg::ONE30;
        if (gn < longint'(thr))
            gn = thr;
        g      = gn;
        gain_q = g[31:0];

        gg   = (g * g) >> 30;
        lvl2 = (lvl * gg) >> 30;

        term = (lvl2 * adj) >> 30;
        sn   = longint'(spd) - longint'(acs_pkg::ONE20) + longint'((term << 20) / spd);
        if (sn > longint'(2 * adj))
            sn = 2 * adj;
        if (sn < longint'(adj))
            sn = adj;
        speed_q = sn[31:0];

        vw = (lvl2 * wet_amt) >> 30;
        if (vw > acs_pkg::HALF_PI)
            vw = acs_pkg::HALF_PI;
        sv = sine_of(vw);
        wp = (sv * wet_amt) >> 30;

        dry   = x * longint'(dry_amt);
        wet   = longint'(wp << (SBITS - 1));
        if (neg)
            wet = -wet;
        total = dry + wet;

        // round half away from zero, then saturate
        mag = (total < 0) ? longint'(-total) : longint'(total);
        rnd = (mag + (acs_pkg::ONE30 >> 1)) >> 30;
        res = (total < 0) ? -longint'(rnd) : longint'(rnd);
        if (res > 64'sd8388607)
            res = 64'sd8388607;
        if (res < -64'sd8388608)
            res = -64'sd8388608;
        return res[SBITS-1:0];
    endfunction

    // Directed table: extremes, sign edges, attack on full scale, recovery on
    // silence. Zero in always gives zero out, whatever the state.
    function automatic row_t directed_row(input int i);
        row_t r;
        r = '{S_ZERO, 1'b0, 1'b0, S_ZERO};
        case (i)
            0:  r = '{S_ZERO, 1'b0, 1'b1, S_ZERO};
            1:  r.sample = S_MAX;
            2:  r.sample = S_MIN;
            3:  r.sample = 24'h000001;
            4:  r = '{24'hFFFFFF, 1'b1, 1'b0, S_ZERO};
            5:  r = '{S_ZERO, 1'b1, 1'b1, S_ZERO};
            6:  r.sample = 24'h400000;
            7:  r.sample = 24'hC00000;
            8:  r.sample = S_MAX;
            9:  r.sample = S_MAX;
            10: r.sample = S_MIN;
            11: r = '{S_MIN, 1'b1, 1'b0, S_ZERO};
            12: r = '{S_ZERO, 1'b0, 1'b1, S_ZERO};
            13: r = '{S_ZERO, 1'b0, 1'b1, S_ZERO};
            14: r.sample = 24'd100;
            15: r.sample = -24'sd100;
            16: r.sample = 24'h555555;
            17: r.sample = 24'hAAAAAA;
            18: r.sample = 24'h0FFFFF;
            default: r = '{S_ZERO, 1'b1, 1'b1, S_ZERO};
        endcase
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 400);
    endfunction

    // Receiver: hold tready low for random stretches while stalls are on.
    always @(negedge clk)
    begin
        if (!rst_n || !rx_stalls_on)
        begin
            m_axis_tready = 1'b1;
            rx_hold       = 0;
        end
        else if (rx_hold > 0)
        begin
            m_axis_tready = 1'b0;
            rx_hold       = rx_hold - 1;
        end
        else
        begin
            m_axis_tready = 1'b1;
            rx_hold       = pick_gap();
        end
    end

    // Output monitor: every accepted word must match the oldest expectation.
    always @(posedge clk)
    begin
        word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word sample=%h last=%b",
                         $time, m_axis_tdata, m_axis_tlast);
                error_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                words_checked++;
                if (m_axis_tdata !== want.sample)
                begin
                    $display("%0t: sample_out expected %h actual %h",
                             $time, want.sample, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $display("%0t: block_last_out expected %b actual %b",
                             $time, want.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    // APB write: setup cycle, then access cycle; mirror it into the predictor.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            acs_pkg::REG_PRESSURE: pressure_q = value[15:0];
            acs_pkg::REG_MIX:      mix_q      = value[15:0];
            acs_pkg::REG_RATE:     rate_q     = value[18:0];
            default:               ;
        endcase
    endtask

    // Drive one sample word; predict at the edge where it is taken.
    // When known is set, the typed-in value replaces the predicted one.
    task automatic send_word(input logic [SBITS-1:0] smp, input logic lst,
                             input bit known, input logic [SBITS-1:0] want);
        word_t w;
        logic [SBITS-1:0] predicted;
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        repeat (gap)
            @(negedge clk);
        if (gap > 0 || !s_axis_tvalid)
            @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = smp;
        s_axis_tlast  = lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = compress_sample(smp);
        w.sample  = known ? want : predicted;
        w.last    = lst;
        expected_words.push_back(w);
        words_sent++;
        // drop valid on the next falling edge; the block stays busy
        // after a take, so the next word waits for tready anyway
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Wait until every expected word came back, then let the pipe settle.
    task automatic drain();
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // Random sample: full range, near-full-scale, quiet, or a tone-like burst
    // around a held amplitude so the gain and speed get driven deep.
    function automatic logic [SBITS-1:0] pick_sample(input int amp, input int idx);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 20)
            return SBITS'($urandom());
        else if (r < 30)
            return ($urandom_range(0, 1) != 0) ? SBITS'(S_MAX - SBITS'($urandom_range(0, 15)))
                                                 : SBITS'(S_MIN + SBITS'($urandom_range(0, 15)));
        else if (r < 45)
            return SBITS'(int'($urandom_range(0, 2000)) - 1000);
        v = amp - int'($urandom_range(0, amp / 8 + 1));
        return (idx % 2 != 0) ? SBITS'(-v) : SBITS'(v);
    endfunction

    initial
    begin
        int phase_items;
        int amp;
        row_t row;
        logic [31:0] p_val, m_val, r_val;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        error_count   = 0;
        words_sent    = 0;
        words_checked = 0;
        settings_used = 1;
        tx_gaps_on    = 1'b0;
        rx_stalls_on  = 1'b0;
        pressure_q    = acs_pkg::PRESSURE_RESET;
        mix_q         = acs_pkg::MIX_RESET;
        rate_q        = acs_pkg::RATE_RESET;
        gain_q        = acs_pkg::GAIN_RESET;
        speed_q       = acs_pkg::SPEED_RESET;

        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at reset settings, first back to back, then with gaps and stalls.
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row        = directed_row(i);
            tx_gaps_on = (i >= DIRECTED_ROWS / 2);
            rx_stalls_on = tx_gaps_on;
            send_word(row.sample, row.last, row.known, row.want);
        end
        drain();

        // Random phases. The first ones pin the register extremes, including
        // a rate scale under the floor; the rest pick settings at random.
        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0: begin p_val = 0;     m_val = 0;     r_val = 8192;   end
                1: begin p_val = 65535; m_val = 65535; r_val = 524287; end
                2: begin p_val = 65535; m_val = 0;     r_val = 100;    end
                3: begin p_val = 0;     m_val = 65535; r_val = 0;      end
                4: begin p_val = 65535; m_val = 65535; r_val = 8192;   end
                default:
                begin
                    p_val = $urandom_range(0, 65535);
                    m_val = $urandom_range(0, 65535);
                    r_val = $urandom_range(8192, 524287);
                end
            endcase
            write_reg(acs_pkg::REG_PRESSURE, p_val);
            write_reg(acs_pkg::REG_MIX, m_val);
            write_reg(acs_pkg::REG_RATE, r_val);
            settings_used++;

            // rotate: gaps and stalls on both sides, gaps only, or stalls only
            tx_gaps_on   = (ph % 3 != 2);
            rx_stalls_on = (ph % 3 != 1);
            phase_items  = 115;
            amp          = $urandom_range(1000, 8388607);
            for (int k = 0; k < phase_items; k++)
            begin
                if ($urandom_range(0, 15) == 0)
                    amp = $urandom_range(1000, 8388607);
                // hold off once per phase until the output side has caught up
                if (k == phase_items / 2)
                    while (expected_words.size() != 0)
                        @(posedge clk);
                send_word(pick_sample(amp, k), $urandom_range(0, 7) == 0, 1'b0, '0);
            end
            drain();
        end

        $display("covered %0d sample words under %0d register settings, %0d checked",
                 words_sent, settings_used, words_checked);
        $display("gaps and stalls on both sides, extremes of every field and register");
        if (error_count == 0)
            $display("adaptive_compressor_saturator_test: clean");
        else
            $display("adaptive_compressor_saturator_test: errors");
        $finish;
    end

endmodule

/* adaptive_compressor_saturator.f */
+incdir+rtl
rtl/acs_pkg.sv
rtl/acs_div.sv
rtl/adaptive_compressor_saturator.sv
rtl/acs_checker.sv
tb/sv/adaptive_compressor_saturator_test.sv
